/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int PDATA_W = 32;
  localparam int PADDR_W = 5;

  // Result action codes
  typedef enum logic [1:0] {
    ACT_DROP    = 2'd0,
    ACT_FRAME   = 2'd1,
    ACT_RT      = 2'd2,
    ACT_RT_DROP = 2'd3
  } sfr_action_t;

  // Configuration register indexes (byte address is 4 times the index)
  typedef enum logic [2:0] {
    REG_START_BYTE  = 3'd0,
    REG_END_BYTE    = 3'd1,
    REG_RT_LOW      = 3'd2,
    REG_RT_HIGH     = 3'd3,
    REG_RT_ACCEPT   = 3'd4
  } sfr_reg_t;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd240;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd247;
  localparam logic [BYTE_W-1:0] RT_LOW_RST     = 8'd248;
  localparam logic [BYTE_W-1:0] RT_HIGH_RST    = 8'd252;
  localparam logic              RT_ACCEPT_RST  = 1'b0;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] realtime_low;
    logic [BYTE_W-1:0] realtime_high;
    logic              realtime_accept;
  } sfr_cfg_t;

  typedef struct packed {
    sfr_action_t action;
    logic        frame_complete;
    logic        overflow;
    logic        frame_open_next;
  } sfr_flags_t;

endpackage

/* rtl/sfr_if.sv */
`timescale 1ns / 1ps

// Input channel: one received byte and the consumer read position per beat
interface sfr_in_if #(
  parameter int FRAME_AW = 7
);
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;
  logic [FRAME_AW-1:0]        consumer_index;

  modport source (output valid, rx_byte, consumer_index, input ready);
  modport sink   (input valid, rx_byte, consumer_index, output ready);
endinterface

// Output channel: one result per accepted byte
interface sfr_out_if #(
  parameter int FRAME_AW = 7,
  parameter int ADDR_W   = 7
);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 action;
  logic [ADDR_W-1:0]          write_addr;
  logic [sfr_pkg::BYTE_W-1:0] write_data;
  logic [FRAME_AW-1:0]        frame_end_index;
  logic                       frame_complete;
  logic                       overflow;
  logic                       in_frame;

  modport source (output valid, action, write_addr, write_data, frame_end_index,
                  frame_complete, overflow, in_frame, input ready);
  modport sink   (input valid, action, write_addr, write_data, frame_end_index,
                  frame_complete, overflow, in_frame, output ready);
endinterface

/* rtl/serial_frame_receiver_realtime_bypass_top.sv */
`timescale 1ns / 1ps

// Serial frame receiver with realtime bypass. Each input beat carries one received
// byte and the consumer's read index; each produces exactly one result beat with
// the ring write it causes (frame ring, realtime ring, or none), the end index of
// completed frames, the frame-complete and overflow flags and the framing state.
// Bytes in [realtime_low, realtime_high] go to the realtime ring when
// realtime_accept is set and never touch the framer. A byte passes through an
// input register and a result register, so its result is presented from the result
// register once it leaves the input register, and a new byte is taken every cycle
// while the output is drained; the rate is set by the framer update between the two
// registers.
// Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 on the APB
// port; pready is always high, and registers should be written only while idle.
module serial_frame_receiver_realtime_bypass_top #(
  parameter int FRAME_RING_DEPTH    = 128,
  parameter int REALTIME_RING_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  sfr_in_if.sink                      in_ch,
  sfr_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sfr_pkg::PADDR_W-1:0] paddr,
  input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
  output logic [sfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int FRAME_AW = $clog2(FRAME_RING_DEPTH);
  localparam int RT_AW    = $clog2(REALTIME_RING_DEPTH);
  localparam int ADDR_W   = (FRAME_AW > RT_AW) ? FRAME_AW : RT_AW;

  sfr_pkg::sfr_cfg_t cfg;

  // Framer state
  logic                frame_open;
  logic [FRAME_AW-1:0] frame_idx;
  logic [FRAME_AW-1:0] end_pos;
  logic [RT_AW-1:0]    rt_idx;

  // Input register
  logic                       s1_valid;
  logic [sfr_pkg::BYTE_W-1:0] s1_rx;
  logic [FRAME_AW-1:0]        s1_consumer;

  // Result register
  logic                       out_valid;
  sfr_pkg::sfr_action_t       out_action;
  logic [ADDR_W-1:0]          out_addr;
  logic [sfr_pkg::BYTE_W-1:0] out_data;
  logic [FRAME_AW-1:0]        out_end;
  logic                       out_complete;
  logic                       out_ovf;
  logic                       out_in_frame;

  sfr_pkg::sfr_flags_t        step_flags;
  logic [FRAME_AW-1:0]        frame_idx_next;
  logic [FRAME_AW-1:0]        end_pos_next;
  logic [RT_AW-1:0]           rt_idx_next;
  logic [ADDR_W-1:0]          step_addr;
  logic [sfr_pkg::BYTE_W-1:0] step_data;

  logic out_free;
  logic s1_fire;
  logic in_fire;
  logic cfg_write;

  assign out_free = !out_valid || out_ch.ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ch.ready = !s1_valid || out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  // APB register writes
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte      <= sfr_pkg::START_BYTE_RST;
      cfg.end_byte        <= sfr_pkg::END_BYTE_RST;
      cfg.realtime_low    <= sfr_pkg::RT_LOW_RST;
      cfg.realtime_high   <= sfr_pkg::RT_HIGH_RST;
      cfg.realtime_accept <= sfr_pkg::RT_ACCEPT_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        sfr_pkg::REG_START_BYTE: cfg.start_byte      <= pwdata[7:0];
        sfr_pkg::REG_END_BYTE:   cfg.end_byte        <= pwdata[7:0];
        sfr_pkg::REG_RT_LOW:     cfg.realtime_low    <= pwdata[7:0];
        sfr_pkg::REG_RT_HIGH:    cfg.realtime_high   <= pwdata[7:0];
        sfr_pkg::REG_RT_ACCEPT:  cfg.realtime_accept <= pwdata[0];
        default: ;
      endcase
    end
  end

  // APB register reads
  always_comb begin
    case (paddr[4:2])
      sfr_pkg::REG_START_BYTE: prdata = sfr_pkg::PDATA_W'(cfg.start_byte);
      sfr_pkg::REG_END_BYTE:   prdata = sfr_pkg::PDATA_W'(cfg.end_byte);
      sfr_pkg::REG_RT_LOW:     prdata = sfr_pkg::PDATA_W'(cfg.realtime_low);
      sfr_pkg::REG_RT_HIGH:    prdata = sfr_pkg::PDATA_W'(cfg.realtime_high);
      sfr_pkg::REG_RT_ACCEPT:  prdata = sfr_pkg::PDATA_W'(cfg.realtime_accept);
      default:                 prdata = '0;
    endcase
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rx       <= in_ch.rx_byte;
      s1_consumer <= in_ch.consumer_index;
    end
  end

  sfr_step #(
    .FRAME_RING_DEPTH    (FRAME_RING_DEPTH),
    .REALTIME_RING_DEPTH (REALTIME_RING_DEPTH),
    .FRAME_AW            (FRAME_AW),
    .RT_AW               (RT_AW),
    .ADDR_W              (ADDR_W)
  ) u_step (
    .cfg            (cfg),
    .frame_open     (frame_open),
    .frame_idx      (frame_idx),
    .end_pos        (end_pos),
    .rt_idx         (rt_idx),
    .rx_byte        (s1_rx),
    .consumer_index (s1_consumer),
    .flags          (step_flags),
    .frame_idx_next (frame_idx_next),
    .end_pos_next   (end_pos_next),
    .rt_idx_next    (rt_idx_next),
    .write_addr     (step_addr),
    .write_data     (step_data)
  );

  // Advance framer state as each byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      frame_idx  <= '0;
      end_pos    <= '0;
      rt_idx     <= '0;
    end else if (s1_fire) begin
      frame_open <= step_flags.frame_open_next;
      frame_idx  <= frame_idx_next;
      end_pos    <= end_pos_next;
      rt_idx     <= rt_idx_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_action   <= step_flags.action;
      out_addr     <= step_addr;
      out_data     <= step_data;
      out_end      <= end_pos_next;
      out_complete <= step_flags.frame_complete;
      out_ovf      <= step_flags.overflow;
      out_in_frame <= step_flags.frame_open_next;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.action          = out_action;
  assign out_ch.write_addr      = out_addr;
  assign out_ch.write_data      = out_data;
  assign out_ch.frame_end_index = out_end;
  assign out_ch.frame_complete  = out_complete;
  assign out_ch.overflow        = out_ovf;
  assign out_ch.in_frame        = out_in_frame;

endmodule

/* rtl/sfr_step.sv */
`timescale 1ns / 1ps

// Classify one byte, run the framer and work out the ring writes and next indexes
module sfr_step #(
  parameter int FRAME_RING_DEPTH    = 128,
  parameter int REALTIME_RING_DEPTH = 16,
  parameter int FRAME_AW            = 7,
  parameter int RT_AW               = 4,
  parameter int ADDR_W              = 7
) (
  input  sfr_pkg::sfr_cfg_t          cfg,
  input  logic                       frame_open,
  input  logic [FRAME_AW-1:0]        frame_idx,
  input  logic [FRAME_AW-1:0]        end_pos,
  input  logic [RT_AW-1:0]           rt_idx,
  input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [FRAME_AW-1:0]        consumer_index,
  output sfr_pkg::sfr_flags_t        flags,
  output logic [FRAME_AW-1:0]        frame_idx_next,
  output logic [FRAME_AW-1:0]        end_pos_next,
  output logic [RT_AW-1:0]           rt_idx_next,
  output logic [ADDR_W-1:0]          write_addr,
  output logic [sfr_pkg::BYTE_W-1:0] write_data
);

  localparam logic [FRAME_AW:0] FRAME_DEPTH_W = (FRAME_AW+1)'(FRAME_RING_DEPTH);
  localparam logic [FRAME_AW-1:0] FRAME_LAST = FRAME_AW'(FRAME_RING_DEPTH - 1);
  localparam logic [RT_AW:0] RT_DEPTH_W = (RT_AW+1)'(REALTIME_RING_DEPTH);

  logic [FRAME_AW:0]   frame_plus1;
  logic [FRAME_AW:0]   frame_plus2;
  logic [FRAME_AW-1:0] frame_inc;
  logic [FRAME_AW-1:0] end_calc;
  logic [RT_AW:0]      rt_plus1;
  logic [RT_AW-1:0]    rt_inc;
  logic                is_rt;
  logic                store;
  logic [FRAME_AW-1:0] before_end;

  // Wrapping index arithmetic
  assign frame_plus1 = {1'b0, frame_idx} + (FRAME_AW+1)'(1);
  assign frame_plus2 = {1'b0, frame_idx} + (FRAME_AW+1)'(2);
  assign frame_inc   = (frame_plus1 >= FRAME_DEPTH_W) ? '0 : frame_plus1[FRAME_AW-1:0];
  assign end_calc    = (frame_plus2 >= FRAME_DEPTH_W) ?
                       FRAME_AW'(frame_plus2 - FRAME_DEPTH_W) : frame_plus2[FRAME_AW-1:0];
  assign rt_plus1    = {1'b0, rt_idx} + (RT_AW+1)'(1);
  assign rt_inc      = (rt_plus1 >= RT_DEPTH_W) ? '0 : rt_plus1[RT_AW-1:0];

  assign is_rt = (rx_byte >= cfg.realtime_low) && (rx_byte <= cfg.realtime_high);

  // Slot just before the end index, taken after any close by this byte
  assign before_end = (end_pos_next == '0) ? FRAME_LAST : end_pos_next - FRAME_AW'(1);

  always_comb begin
    flags.action          = sfr_pkg::ACT_DROP;
    flags.frame_complete  = 1'b0;
    flags.overflow        = 1'b0;
    flags.frame_open_next = frame_open;
    frame_idx_next        = frame_idx;
    end_pos_next          = end_pos;
    rt_idx_next           = rt_idx;
    write_addr            = '0;
    write_data            = '0;
    store                 = 1'b0;

    if (is_rt) begin
      // Realtime bytes bypass the framer
      if (cfg.realtime_accept) begin
        flags.action = sfr_pkg::ACT_RT;
        write_addr   = ADDR_W'(rt_idx);
        write_data   = rx_byte;
        rt_idx_next  = rt_inc;
      end else begin
        flags.action = sfr_pkg::ACT_RT_DROP;
      end
    end else begin
      store = 1'b1;
      if (!frame_open) begin
        if (rx_byte == cfg.start_byte) begin
          flags.frame_open_next = 1'b1;
        end else begin
          store = 1'b0;
        end
      end else if (rx_byte == cfg.end_byte) begin
        end_pos_next          = end_calc;
        flags.frame_open_next = 1'b0;
        flags.frame_complete  = 1'b1;
      end else if (rx_byte == cfg.start_byte) begin
        // Repeated start: drop and return to idle
        store                 = 1'b0;
        flags.frame_open_next = 1'b0;
      end

      if (store) begin
        flags.action   = sfr_pkg::ACT_FRAME;
        write_addr     = ADDR_W'(frame_idx);
        write_data     = rx_byte;
        frame_idx_next = frame_inc;
        flags.overflow = (frame_inc == consumer_index) && (frame_inc != before_end);
      end
    end
  end

endmodule

/* rtl/sfr_checker.sv */
`timescale 1ns / 1ps

// Port-level checks on the result channel
module sfr_checker #(
  parameter int FRAME_AW = 7,
  parameter int ADDR_W   = 7
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 out_action,
  input logic [ADDR_W-1:0]          out_write_addr,
  input logic [sfr_pkg::BYTE_W-1:0] out_write_data,
  input logic [FRAME_AW-1:0]        out_frame_end_index,
  input logic                       out_frame_complete,
  input logic                       out_overflow,
  input logic                       out_in_frame
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
    $stable(out_write_addr) && $stable(out_write_data) &&
    $stable(out_frame_end_index) && $stable(out_in_frame))
    else $error("result beat changed while stalled");

  // Beats with no ring write carry zero address, data and overflow
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_action == sfr_pkg::ACT_DROP || out_action == sfr_pkg::ACT_RT_DROP)
    |-> out_write_addr == '0 && out_write_data == '0 && !out_overflow)
    else $error("dropped byte shows a write");

  // Overflow only on frame ring stores
  a_ovf_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_overflow |-> out_action == sfr_pkg::ACT_FRAME)
    else $error("overflow without frame store");

  // A closing byte is stored and leaves the framer idle
  a_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_complete |-> out_action == sfr_pkg::ACT_FRAME && !out_in_frame)
    else $error("frame close without store or still in frame");

  // A store that leaves the framer idle must be the closing byte
  a_idle_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_action == sfr_pkg::ACT_FRAME && !out_in_frame |-> out_frame_complete)
    else $error("frame store while idle");

endmodule

bind serial_frame_receiver_realtime_bypass_top sfr_checker #(
  .FRAME_AW (FRAME_AW),
  .ADDR_W   (ADDR_W)
) u_sfr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_action          (out_ch.action),
  .out_write_addr      (out_ch.write_addr),
  .out_write_data      (out_ch.write_data),
  .out_frame_end_index (out_ch.frame_end_index),
  .out_frame_complete  (out_ch.frame_complete),
  .out_overflow        (out_ch.overflow),
  .out_in_frame        (out_ch.in_frame)
);
